FILE: src/rle_sprite_clip_blitter_core_defines.svh
// ----------------------------------------------------------------------------
// RLE sprite clip blitter: assertion macros
// Shared concurrent-assertion shorthands. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RLE_SPRITE_CLIP_BLITTER_CORE_DEFINES_SVH
`define RLE_SPRITE_CLIP_BLITTER_CORE_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define RSCB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define RSCB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RSCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rscb_pkg.sv
// ----------------------------------------------------------------------------
// RLE sprite clip blitter package
// Codes, field widths and constants shared by the interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package rscb_pkg;

    localparam int DIM_W    = 12;   // sprite width/height field
    localparam int CNT_W    = 13;   // column/row walk counters
    localparam int DEPTH_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int RUN_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]  CNT_SAT      = 13'd4096;
    localparam logic [BYTE_W-1:0] SHADOW_INDEX = 8'd254;
    localparam logic [BYTE_W-1:0] END_OF_ROW   = 8'd0;

    typedef enum logic [0:0] {
        FUNC_START = 1'b0,
        FUNC_BYTE  = 1'b1
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT   = 2'd0,
        CFG_CLIP_TOP    = 2'd1,
        CFG_CLIP_RIGHT  = 2'd2,
        CFG_CLIP_BOTTOM = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

FILE: src/rscb_if.sv
// ----------------------------------------------------------------------------
// RLE sprite clip blitter channel interfaces
// Valid/ready request channels for source items and pixel commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface rscb_in_if #(
    parameter int COORD_BITS = 16
);
    import rscb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [BYTE_W-1:0]      src_byte;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [DIM_W-1:0]       sprite_width;
    logic [DIM_W-1:0]       sprite_height;
    logic [DEPTH_W-1:0]     depth_in;

    modport source (
        output valid, func, src_byte, pos_x, pos_y, sprite_width, sprite_height, depth_in,
        input  ready
    );
    modport sink (
        input  valid, func, src_byte, pos_x, pos_y, sprite_width, sprite_height, depth_in,
        output ready
    );
endinterface

interface rscb_out_if #(
    parameter int COORD_BITS = 16
);
    import rscb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  pix_x;
    logic [COORD_BITS-1:0]  pix_y;
    logic                   is_shadow;
    logic [BYTE_W-1:0]      color_index;
    logic [DEPTH_W-1:0]     depth_out;

    modport source (
        output valid, pix_x, pix_y, is_shadow, color_index, depth_out,
        input  ready
    );
    modport sink (
        input  valid, pix_x, pix_y, is_shadow, color_index, depth_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/rle_sprite_clip_blitter_core.sv
// ----------------------------------------------------------------------------
// RLE sprite clip blitter core
// Walks a run-length coded transparent sprite and emits clipped pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries requests: func = start (origin, size, depth latched, walk
//          reset to row 0 column 0) or func = byte (one stream byte).
//   out_ch carries pixel commands: screen x/y, shadow flag, palette index and
//          the sprite depth for the downstream compare and write stage.
//   cfg_*  sets the clip rectangle (left, top, right, bottom); write it only
//          while no request is in flight.
// Output: a visible literal pixel byte shows its command on out_ch in the
//   cycle after it is accepted. Requests that give no command
//   (start, run headers, end of row, clipped pixels) leave nothing behind.
// Throughput: one request per cycle unless out_ch stalls. The walk state and the
//   single output register update in the same cycle from the adds and clip test.
// Stall: while a command waits unaccepted, in_ch.ready drops and the walk
//   state holds; a command taken in the same cycle frees the slot at once.
// Reset: clip rectangle returns to 0,0,640,480, the job to zero size, the
//   output register to empty. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rle_sprite_clip_blitter_core_defines.svh"

module rle_sprite_clip_blitter_core #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rscb_in_if.sink                              in_ch,
    rscb_out_if.source                           out_ch,
    input  wire logic                            cfg_we,
    input  wire rscb_pkg::cfg_reg_t              cfg_index,
    input  wire logic [COORD_BITS-1:0]           cfg_wdata
);
    import rscb_pkg::*;

    // Screen sums need room for the sign-extended origin plus a column count.
    localparam int SUM_W = ((COORD_BITS > CNT_W) ? COORD_BITS : CNT_W) + 1;

    // Clip rectangle
    logic [COORD_BITS-1:0] clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;

    // Job and walk state
    logic [COORD_BITS-1:0] job_x_reg, job_y_reg;
    logic [DIM_W-1:0]      job_width_reg, job_height_reg;
    logic [DEPTH_W-1:0]    job_depth_reg;
    logic [CNT_W-1:0]      cur_col_reg, cur_col_next;
    logic [CNT_W-1:0]      cur_row_reg, cur_row_next;
    logic [RUN_W-1:0]      run_left_reg, run_left_next;
    logic                  in_literal_reg, in_literal_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pix_x_reg, pix_y_reg;
    logic                  is_shadow_reg;
    logic [BYTE_W-1:0]     color_index_reg;
    logic [DEPTH_W-1:0]    depth_out_reg;

    logic                  in_fire;
    logic                  is_start;
    logic                  literal_hit;
    logic                  in_bounds;
    logic                  visible;
    logic                  emit;
    logic [BYTE_W-1:0]     b;
    logic [CNT_W:0]        col_skip_sum;
    logic [CNT_W:0]        col_inc_sum;
    logic [CNT_W:0]        row_inc_sum;
    logic signed [SUM_W-1:0] sx, sy;
    logic signed [SUM_W-1:0] c_left, c_top, c_right, c_bottom;

    // ------------------------------------------------------------------
    // Handshake: take a request whenever the output slot is free or drains
    // ------------------------------------------------------------------
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign is_start    = (in_ch.func == FUNC_START);
    assign b           = in_ch.src_byte;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= COORD_BITS'(640);
            clip_bottom_reg <= COORD_BITS'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLIP_LEFT:   clip_left_reg   <= cfg_wdata;
                CFG_CLIP_TOP:    clip_top_reg    <= cfg_wdata;
                CFG_CLIP_RIGHT:  clip_right_reg  <= cfg_wdata;
                CFG_CLIP_BOTTOM: clip_bottom_reg <= cfg_wdata;
                default:         clip_left_reg   <= clip_left_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pixel position and clip test for the current walk position
    // ------------------------------------------------------------------
    assign literal_hit = in_literal_reg && (run_left_reg != '0);
    assign in_bounds   = (cur_col_reg < {1'b0, job_width_reg}) &&
                         (cur_row_reg < {1'b0, job_height_reg});

    assign sx = signed'({{(SUM_W-COORD_BITS){job_x_reg[COORD_BITS-1]}}, job_x_reg})
              + signed'({{(SUM_W-CNT_W){1'b0}}, cur_col_reg});
    assign sy = signed'({{(SUM_W-COORD_BITS){job_y_reg[COORD_BITS-1]}}, job_y_reg})
              + signed'({{(SUM_W-CNT_W){1'b0}}, cur_row_reg});

    assign c_left   = signed'({{(SUM_W-COORD_BITS){clip_left_reg[COORD_BITS-1]}},
                               clip_left_reg});
    assign c_top    = signed'({{(SUM_W-COORD_BITS){clip_top_reg[COORD_BITS-1]}},
                               clip_top_reg});
    assign c_right  = signed'({{(SUM_W-COORD_BITS){clip_right_reg[COORD_BITS-1]}},
                               clip_right_reg});
    assign c_bottom = signed'({{(SUM_W-COORD_BITS){clip_bottom_reg[COORD_BITS-1]}},
                               clip_bottom_reg});

    assign visible = (sx >= c_left) && (sx < c_right) && (sy >= c_top) && (sy < c_bottom);
    assign emit    = in_fire && !is_start && literal_hit && in_bounds && visible;

    // ------------------------------------------------------------------
    // Walk state update
    // ------------------------------------------------------------------
    assign col_skip_sum = {1'b0, cur_col_reg} + {{(CNT_W+1-RUN_W){1'b0}}, b[RUN_W-1:0]};
    assign col_inc_sum  = {1'b0, cur_col_reg} + (CNT_W+1)'(1);
    assign row_inc_sum  = {1'b0, cur_row_reg} + (CNT_W+1)'(1);

    always_comb
    begin
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        run_left_next   = run_left_reg;
        in_literal_next = in_literal_reg;
        if (in_fire)
        begin
            priority if (is_start)
            begin
                cur_col_next    = '0;
                cur_row_next    = '0;
                run_left_next   = '0;
                in_literal_next = 1'b0;
            end
            else if (literal_hit)
            begin
                // Consume one literal pixel, saturate the column
                cur_col_next    = (col_inc_sum > {1'b0, CNT_SAT}) ? CNT_SAT
                                                                  : col_inc_sum[CNT_W-1:0];
                run_left_next   = run_left_reg - RUN_W'(1);
                in_literal_next = (run_left_reg != RUN_W'(1));
            end
            else if (b[BYTE_W-1])
            begin
                // Transparent run: advance the column only
                cur_col_next    = (col_skip_sum > {1'b0, CNT_SAT}) ? CNT_SAT
                                                                   : col_skip_sum[CNT_W-1:0];
                run_left_next   = '0;
                in_literal_next = 1'b0;
            end
            else if (b == END_OF_ROW)
            begin
                cur_row_next    = (row_inc_sum > {1'b0, CNT_SAT}) ? CNT_SAT
                                                                  : row_inc_sum[CNT_W-1:0];
                cur_col_next    = '0;
                run_left_next   = '0;
                in_literal_next = 1'b0;
            end
            else
            begin
                // Literal run header
                run_left_next   = b[RUN_W-1:0];
                in_literal_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            run_left_reg   <= '0;
            in_literal_reg <= 1'b0;
            job_x_reg      <= '0;
            job_y_reg      <= '0;
            job_width_reg  <= '0;
            job_height_reg <= '0;
            job_depth_reg  <= '0;
        end
        else
        begin
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            run_left_reg   <= run_left_next;
            in_literal_reg <= in_literal_next;
            if (in_fire && is_start)
            begin
                job_x_reg      <= in_ch.pos_x;
                job_y_reg      <= in_ch.pos_y;
                job_width_reg  <= in_ch.sprite_width;
                job_height_reg <= in_ch.sprite_height;
                job_depth_reg  <= in_ch.depth_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on a visible pixel, drop when taken
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (emit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_x_reg       <= sx[COORD_BITS-1:0];
            pix_y_reg       <= sy[COORD_BITS-1:0];
            is_shadow_reg   <= (b == SHADOW_INDEX);
            color_index_reg <= b;
            depth_out_reg   <= job_depth_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pix_x       = pix_x_reg;
    assign out_ch.pix_y       = pix_y_reg;
    assign out_ch.is_shadow   = is_shadow_reg;
    assign out_ch.color_index = color_index_reg;
    assign out_ch.depth_out   = depth_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RSCB_ASSERT_SAME(a_literal_has_count, in_literal_reg, run_left_reg != '0, "literal run with zero count")
    `RSCB_ASSERT_ALWAYS(a_counters_saturate, (cur_col_reg <= CNT_SAT) && (cur_row_reg <= CNT_SAT), "walk counter past saturation")
    `RSCB_ASSERT_NEXT(a_start_resets_walk, in_fire && is_start, (cur_col_reg == '0) && (cur_row_reg == '0) && !in_literal_reg, "start did not reset the walk")
    `RSCB_ASSERT_SAME(a_stall_blocks_input, out_valid_reg && !out_ch.ready, !in_ch.ready, "request taken while output slot is full")
    `RSCB_ASSERT_NEXT(a_emit_loads_output, emit, out_valid_reg, "visible pixel not presented")

endmodule

`default_nettype wire

FILE: tb/sv/rle_sprite_clip_blitter_core_tb.sv
// ----------------------------------------------------------------------------
// RLE sprite clip blitter core testbench
// Streams sprite jobs through the request channel and checks every pixel
// command against a cycle-free model of the row/column walk and the clip test.
// Clip rectangles change between phases, and both channels stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_sprite_clip_blitter_core_tb;

    import rscb_pkg::*;

    localparam int COORD_BITS    = 16;
    localparam int SETTLE_CYCLES = 4;       // quiet cycles before a clip write
    localparam int TAIL_CYCLES   = 8;       // extra cycles after the last command
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_QUOTA   = 135;

    typedef logic [COORD_BITS-1:0] coord_t;

    // One request as the sender presents it.
    typedef struct {
        func_t              func;
        logic [BYTE_W-1:0]  src_byte;
        coord_t             pos_x;
        coord_t             pos_y;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [DEPTH_W-1:0] depth;
    } sprite_req_t;

    // One pixel command as the block should emit it.
    typedef struct {
        coord_t             x;
        coord_t             y;
        logic               shadow;
        logic [BYTE_W-1:0]  color;
        logic [DEPTH_W-1:0] depth;
    } pixel_cmd_t;

    typedef enum {
        STEP_REQUEST,
        STEP_CLIP_WRITE,
        STEP_DRAIN,
        STEP_IDLING
    } step_kind_t;

    // Entry of the job script the driver walks through in order.
    typedef struct {
        step_kind_t  kind;
        sprite_req_t req;
        cfg_reg_t    reg_sel;
        coord_t      value;
        int          src_pct;
        int          snk_pct;
    } script_step_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_reg_t cfg_index;
    coord_t cfg_wdata;

    rscb_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
    rscb_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

    rle_sprite_clip_blitter_core #(
        .COORD_BITS (COORD_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    script_step_t job_script [$];       // everything the driver still has to do
    pixel_cmd_t   pending_pixels [$];   // commands predicted but not yet seen
    int           planned_requests = 0;
    int           error_count = 0;
    int           cycle_count = 0;
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;
    int           quiet_cycles = 0;

    // Clip corners the stimulus generator aims sprites at.
    coord_t plan_clip_left = '0;
    coord_t plan_clip_top  = '0;

    // ------------------------------------------------------------------------
    // Sprite walk model: its own copy of the clip rectangle and walk state
    // ------------------------------------------------------------------------
    coord_t              clip_bound [4] = '{16'd0, 16'd0, 16'd640, 16'd480};
    logic [RUN_W-1:0]    run_left = '0;
    logic                in_literal = 1'b0;
    logic [CNT_W-1:0]    walk_col = '0;
    logic [CNT_W-1:0]    walk_row = '0;
    coord_t              job_x = '0;
    coord_t              job_y = '0;
    logic [DIM_W-1:0]    job_width = '0;
    logic [DIM_W-1:0]    job_height = '0;
    logic [DEPTH_W-1:0]  job_depth = '0;

    function automatic int as_coord(coord_t v);
        return $signed(v);
    endfunction

    // Counters stop at CNT_SAT, past any sprite size.
    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c, int step);
        int s;
        s = int'(c) + step;
        return (s > int'(CNT_SAT)) ? CNT_SAT : s[CNT_W-1:0];
    endfunction

    // Advance the walk by one accepted request; queue the command it causes.
    task automatic blit_step(sprite_req_t r);
        logic [BYTE_W-1:0] b;
        logic [CNT_W-1:0]  col;
        logic [CNT_W-1:0]  row;
        int                x;
        int                y;
        pixel_cmd_t        cmd;
        b = r.src_byte;
        if (r.func == FUNC_START)
        begin
            // Latch the job and restart the walk; any open run is dropped.
            job_x      = r.pos_x;
            job_y      = r.pos_y;
            job_width  = r.width;
            job_height = r.height;
            job_depth  = r.depth;
            run_left   = '0;
            in_literal = 1'b0;
            walk_col   = '0;
            walk_row   = '0;
        end
        else if (in_literal && run_left != 0)
        begin
            col = walk_col;
            row = walk_row;
            walk_col = bump(walk_col, 1);
            run_left = run_left - 1'b1;
            if (run_left == 0)
                in_literal = 1'b0;
            if (int'(col) < int'(job_width) && int'(row) < int'(job_height))
            begin
                x = as_coord(job_x) + int'(col);
                y = as_coord(job_y) + int'(row);
                if (x >= as_coord(clip_bound[CFG_CLIP_LEFT]) &&
                    x <  as_coord(clip_bound[CFG_CLIP_RIGHT]) &&
                    y >= as_coord(clip_bound[CFG_CLIP_TOP]) &&
                    y <  as_coord(clip_bound[CFG_CLIP_BOTTOM]))
                begin
                    cmd.x      = x[COORD_BITS-1:0];
                    cmd.y      = y[COORD_BITS-1:0];
                    cmd.shadow = (b == SHADOW_INDEX);
                    cmd.color  = b;
                    cmd.depth  = job_depth;
                    pending_pixels.push_back(cmd);
                end
            end
        end
        else
        begin
            in_literal = 1'b0;
            run_left   = '0;
            if (b[7])
                walk_col = bump(walk_col, int'(b[6:0]));
            else if (b == END_OF_ROW)
            begin
                walk_row = bump(walk_row, 1);
                walk_col = '0;
            end
            else
            begin
                run_left   = b[RUN_W-1:0];
                in_literal = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Script building
    // ------------------------------------------------------------------------
    task automatic plan_request(func_t f, logic [BYTE_W-1:0] b, coord_t x, coord_t y,
                                logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                logic [DEPTH_W-1:0] d);
        script_step_t s;
        s.kind         = STEP_REQUEST;
        s.req.func     = f;
        s.req.src_byte = b;
        s.req.pos_x    = x;
        s.req.pos_y    = y;
        s.req.width    = w;
        s.req.height   = h;
        s.req.depth    = d;
        job_script.push_back(s);
        planned_requests++;
    endtask

    // Stream byte; the fields it leaves unused carry noise.
    task automatic plan_byte(logic [BYTE_W-1:0] b);
        plan_request(FUNC_BYTE, b, 16'($urandom), 16'($urandom), 12'($urandom),
                     12'($urandom), 16'($urandom));
    endtask

    task automatic plan_start(coord_t x, coord_t y, logic [DIM_W-1:0] w,
                              logic [DIM_W-1:0] h, logic [DEPTH_W-1:0] d);
        plan_request(FUNC_START, 8'($urandom), x, y, w, h, d);
    endtask

    task automatic plan_drain();
        script_step_t s;
        s.kind = STEP_DRAIN;
        job_script.push_back(s);
    endtask

    // One phase: set idling, write the clip rectangle, then stream sprites.
    task automatic plan_phase(int src_pct, int snk_pct, coord_t l, coord_t t,
                              coord_t r, coord_t b, int quota);
        script_step_t s;
        coord_t       corner [4];
        int           first;
        int           drained;
        int           pick;
        int           w;
        int           h;
        int           rows;
        int           lim;
        int           col;
        int           n;
        coord_t       x;
        coord_t       y;
        corner = '{l, t, r, b};
        s.kind    = STEP_IDLING;
        s.src_pct = src_pct;
        s.snk_pct = snk_pct;
        job_script.push_back(s);
        for (int i = 0; i < 4; i++)
        begin
            s.kind    = STEP_CLIP_WRITE;
            s.reg_sel = cfg_reg_t'(i);
            s.value   = corner[i];
            job_script.push_back(s);
        end
        plan_clip_left = l;
        plan_clip_top  = t;
        first   = planned_requests;
        drained = 0;
        while (planned_requests - first < quota)
        begin
            // Hold the sender once per phase until every command is back.
            if (!drained && planned_requests - first >= quota / 2)
            begin
                plan_drain();
                drained = 1;
            end
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                // Noise: raw requests with every field random.
                repeat ($urandom_range(1, 6))
                    plan_request(func_t'($urandom_range(0, 1)), 8'($urandom),
                                 16'($urandom), 16'($urandom), 12'($urandom),
                                 12'($urandom), 16'($urandom));
            end
            else
            begin
                // Mostly small sprites; now and then the largest sizes.
                if (pick == 1)
                begin
                    w = 4095;
                    h = $urandom_range(1, 4095);
                end
                else if (pick == 2)
                begin
                    w = $urandom_range(0, 4095);
                    h = $urandom_range(0, 4095);
                end
                else
                begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 10);
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                else
                begin
                    x = plan_clip_left + 16'($urandom_range(0, 80)) - 16'd40;
                    y = plan_clip_top + 16'($urandom_range(0, 40)) - 16'd20;
                end
                plan_start(x, y, w[DIM_W-1:0], h[DIM_W-1:0], 16'($urandom));
                rows = (h > 12) ? 3 : h + $urandom_range(0, 1);
                lim  = (w > 40) ? 40 : w + $urandom_range(0, 2);
                if (pick == 1 && $urandom_range(0, 1) == 1)
                begin
                    // Push the column counter into saturation, then draw.
                    repeat (33)
                        plan_byte(8'hFF);
                    plan_byte(8'h02);
                    plan_byte(8'($urandom));
                    plan_byte(8'($urandom));
                    rows = 0;
                end
                for (int k = 0; k < rows; k++)
                begin
                    col = 0;
                    while (col < lim)
                    begin
                        if ($urandom_range(0, 2) == 0)
                        begin
                            n = $urandom_range(0, 6);
                            plan_byte(8'h80 | n[BYTE_W-1:0]);
                        end
                        else
                        begin
                            n = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 127)
                                                             : $urandom_range(1, 8);
                            plan_byte(n[BYTE_W-1:0]);
                            // Cut a run short now and then.
                            if ($urandom_range(0, 39) == 0)
                                n = $urandom_range(0, n - 1);
                            repeat (n)
                                plan_byte(($urandom_range(0, 5) == 0) ? SHADOW_INDEX
                                                                      : 8'($urandom));
                        end
                        col += n;
                    end
                    plan_byte(END_OF_ROW);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and cycle counter
    // ------------------------------------------------------------------------
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // ------------------------------------------------------------------------
    // Driver: walk the job script, one entry at a time
    // ------------------------------------------------------------------------
    sprite_req_t shown_req;     // request currently on the channel
    sprite_req_t next_req;
    logic        send_next;
    logic        write_next;
    cfg_reg_t    write_sel;
    coord_t      write_value;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            cfg_we       <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            send_next   = in_ch.valid;
            next_req    = shown_req;
            write_next  = 1'b0;
            write_sel   = cfg_index;
            write_value = cfg_wdata;

            // Request taken: advance the model, free the channel.
            if (in_ch.valid && in_ch.ready)
            begin
                blit_step(shown_req);
                send_next = 1'b0;
            end

            // Count cycles with nothing on the channel and nothing pending.
            if (in_ch.valid || pending_pixels.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (!send_next && job_script.size() != 0)
            begin
                case (job_script[0].kind)
                    STEP_IDLING:
                    begin
                        src_idle_pct <= job_script[0].src_pct;
                        snk_idle_pct <= job_script[0].snk_pct;
                        void'(job_script.pop_front());
                    end
                    STEP_DRAIN:
                    begin
                        // Hold off until every predicted command has arrived.
                        if (pending_pixels.size() == 0)
                            void'(job_script.pop_front());
                    end
                    STEP_CLIP_WRITE:
                    begin
                        // Write only once the block has settled.
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            write_next  = 1'b1;
                            write_sel   = job_script[0].reg_sel;
                            write_value = job_script[0].value;
                            clip_bound[write_sel] = write_value;
                            void'(job_script.pop_front());
                        end
                    end
                    default:
                    begin
                        // Idle at random before presenting the next request.
                        if ($urandom_range(0, 99) >= src_idle_pct)
                        begin
                            next_req  = job_script[0].req;
                            send_next = 1'b1;
                            void'(job_script.pop_front());
                        end
                    end
                endcase
            end

            in_ch.valid         <= send_next;
            in_ch.func          <= next_req.func;
            in_ch.src_byte      <= next_req.src_byte;
            in_ch.pos_x         <= next_req.pos_x;
            in_ch.pos_y         <= next_req.pos_y;
            in_ch.sprite_width  <= next_req.width;
            in_ch.sprite_height <= next_req.height;
            in_ch.depth_in      <= next_req.depth;
            cfg_we              <= write_next;
            cfg_index           <= write_sel;
            cfg_wdata           <= write_value;
            shown_req = next_req;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each command taken against the oldest prediction
    // ------------------------------------------------------------------------
    pixel_cmd_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected command: expected none, got x=%0d y=%0d shadow=%0d index=%0d depth=%0d",
                             $time, $signed(out_ch.pix_x), $signed(out_ch.pix_y),
                             out_ch.is_shadow, out_ch.color_index, out_ch.depth_out);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (out_ch.pix_x !== want.x || out_ch.pix_y !== want.y ||
                        out_ch.is_shadow !== want.shadow ||
                        out_ch.color_index !== want.color ||
                        out_ch.depth_out !== want.depth)
                    begin
                        error_count++;
                        $display("%0t: command mismatch: expected x=%0d y=%0d shadow=%0d index=%0d depth=%0d, got x=%0d y=%0d shadow=%0d index=%0d depth=%0d",
                                 $time, $signed(want.x), $signed(want.y), want.shadow,
                                 want.color, want.depth, $signed(out_ch.pix_x),
                                 $signed(out_ch.pix_y), out_ch.is_shadow,
                                 out_ch.color_index, out_ch.depth_out);
                    end
                end
            end
            // Stall the command channel at random.
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_CLIP_LEFT;
        cfg_wdata           = '0;
        in_ch.valid         = 1'b0;
        in_ch.func          = FUNC_START;
        in_ch.src_byte      = '0;
        in_ch.pos_x         = '0;
        in_ch.pos_y         = '0;
        in_ch.sprite_width  = '0;
        in_ch.sprite_height = '0;
        in_ch.depth_in      = '0;
        out_ch.ready        = 1'b0;

        // Directed part, reset clip rectangle, sender 13 / receiver 79 idling.
        src_idle_pct = 13;
        snk_idle_pct = 79;
        // Bytes before any start: zero-size job, nothing comes out.
        plan_byte(8'h05);
        plan_byte(SHADOW_INDEX);
        plan_start(16'd0, 16'd0, 12'd4, 12'd2, 16'hFFFF);
        plan_byte(8'h05);               // literal run of five, one past the width
        plan_byte(SHADOW_INDEX);
        plan_byte(8'hFF);
        plan_byte(8'h00);
        plan_byte(8'h01);
        plan_byte(8'h80);               // consumed past the width
        plan_byte(8'h80);               // transparent run of zero length
        plan_byte(END_OF_ROW);
        plan_byte(8'h81);               // skip one column
        plan_byte(8'h02);
        plan_byte(8'h7F);
        plan_byte(8'h55);
        plan_byte(END_OF_ROW);
        plan_byte(8'h01);               // row past the height
        plan_byte(8'h33);
        plan_start(16'd32767, 16'h8000, 12'd4095, 12'd4095, 16'd0);
        plan_byte(8'h7F);
        plan_byte(8'hAA);
        // Start in mid-run: the open run is dropped.
        plan_start(16'hFFFE, 16'hFFFF, 12'd3, 12'd3, 16'h1234);
        plan_byte(8'h03);
        plan_byte(8'h10);
        plan_byte(8'h20);
        plan_byte(8'h30);

        // Random phases, each with its own clip rectangle.
        plan_phase(13, 79, 16'hFFF0, 16'hFFF8, 16'd48, 16'd40, PHASE_QUOTA);
        plan_phase(13, 79, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, PHASE_QUOTA);
        plan_phase(79, 13, 16'd20, 16'd0, 16'd20, 16'd100, PHASE_QUOTA);
        plan_phase(79, 13, 16'd10, 16'd5, 16'd30, 16'd25, PHASE_QUOTA);
        plan_phase(0, 0, 16'd0, 16'd50, 16'd640, 16'hFFCE, PHASE_QUOTA);
        plan_phase(0, 0, 16'd0, 16'd0, 16'd640, 16'd480, PHASE_QUOTA);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the last request, the last command, then a short tail.
        while (job_script.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: rle_sprite_clip_blitter_core.f
+incdir+src
src/rscb_pkg.sv
src/rscb_if.sv
src/rle_sprite_clip_blitter_core.sv
tb/sv/rle_sprite_clip_blitter_core_tb.sv
